// ----- rtl/rarsm_pkg.sv -----
// Package for the range add / range sum modulo unit.
// Holds sizing constants, function codes and block index helpers.
// No dependencies.
package rarsm_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int BLK_LEN      = 32;
  localparam int NUM_BLOCKS   = (NUM_ELEMENTS + BLK_LEN - 1) / BLK_LEN;
  localparam int IDX_W        = 10;
  localparam int BLK_W        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int EL_AW        = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int WORD_W       = 64;
  localparam int ROW_W        = 2 * WORD_W;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] SEG_A   = 2'd0;
  localparam logic [1:0] SEG_MID = 2'd1;
  localparam logic [1:0] SEG_C   = 2'd2;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [BLK_W-1:0] blk_of(input logic [IDX_W-1:0] idx);
    return BLK_W'(int'(idx) / BLK_LEN);
  endfunction

  function automatic logic [IDX_W-1:0] blk_lo(input logic [BLK_W-1:0] b);
    return IDX_W'(int'(b) * BLK_LEN);
  endfunction

  function automatic logic [IDX_W-1:0] blk_hi(input logic [BLK_W-1:0] b);
    int h;
    h = int'(b) * BLK_LEN + BLK_LEN - 1;
    if (h > NUM_ELEMENTS - 1) h = NUM_ELEMENTS - 1;
    return IDX_W'(h);
  endfunction

endpackage

// ----- rtl/rarsm_ram.sv -----
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module rarsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/rarsm_div.sv -----
// Bit-serial remainder unit: 64-bit dividend modulo 32-bit divisor, one bit a cycle.
// Depends on rarsm_pkg.
module rarsm_div
  import rarsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [WORD_W-1:0] dvd_q;
  logic [31:0]       dvs_q;
  logic [31:0]       rem_q;
  logic [6:0]        cnt_q;
  logic              run_q;
  logic              done_q;
  logic [32:0]       trial;

  assign trial = {rem_q, dvd_q[WORD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= 7'(WORD_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= 32'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= trial[31:0];
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- rtl/range_add_range_sum_mod_unit.sv -----
// Range add / range sum modulo unit; one item at a time, results cannot be stalled.
// Load: the block row and element are read, then the element and block total written.
// Range add: end-block elements updated one by one, whole blocks through their row.
// Query: each element or whole-block total through the 64-step remainder unit; a bad
// range or zero modulus goes straight to the result. Reset clears block totals and
// pending adds through per-block valid bits and zeroes all 1024 elements, busy held high.
module range_add_range_sum_mod_unit
  import rarsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       func_i,
  input  logic [IDX_W-1:0] first_index_i,
  input  logic [IDX_W-1:0] last_index_i,
  input  logic [31:0]      value_i,
  input  logic [31:0]      modulus_i,
  output logic             sum_mod_valid_o,
  output logic [31:0]      sum_mod_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROW_RD = 3'd1;
  localparam logic [2:0] S_ROW_LD = 3'd2;
  localparam logic [2:0] S_EL_RD  = 3'd3;
  localparam logic [2:0] S_EL_OP  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_ROW_WR = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [NUM_BLOCKS-1:0] vld_q, vld_d;
  logic [1:0]        func_q, func_d;
  logic [1:0]        seg_q, seg_d;
  logic [IDX_W-1:0]  idx_q, idx_d, end_q, end_d, last_q, last_d;
  logic [BLK_W-1:0]  blk_q, blk_d, rb_q, rb_d;
  logic [31:0]       val_q, val_d, mod_q, mod_d, acc_q, acc_d;
  logic [WORD_W-1:0] tot_q, tot_d, pend_q, pend_d;
  logic              clr_q, clr_d;
  logic [EL_AW-1:0]  clr_cnt_q, clr_cnt_d;

  logic              el_we, row_we;
  logic [EL_AW-1:0]  el_waddr;
  logic [WORD_W-1:0] el_wdata, el_rdata;
  logic [ROW_W-1:0]  row_wdata, row_rdata, row_in;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              go_seg_end, go_mid_next, last_el, ok;
  logic [BLK_W-1:0]  blk_nx, lb_in, rb_in;
  logic [32:0]       msum;

  rarsm_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ELEMENTS)) u_el_ram (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (el_waddr),
    .wdata_i (el_wdata),
    .raddr_i (EL_AW'(idx_q)),
    .rdata_o (el_rdata)
  );

  rarsm_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BLOCKS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (blk_q),
    .wdata_i (row_wdata),
    .raddr_i (blk_q),
    .rdata_o (row_rdata)
  );

  rarsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign el_waddr = clr_q ? clr_cnt_q : EL_AW'(idx_q);
  assign last_el = (idx_q == end_q);
  assign blk_nx  = BLK_W'(blk_q + 1'b1);
  assign lb_in   = blk_of(first_index_i);
  assign rb_in   = blk_of(last_index_i);
  assign ok      = (first_index_i <= last_index_i) &&
                   ({1'b0, last_index_i} < (IDX_W+1)'(NUM_ELEMENTS));
  assign row_in  = vld_q[blk_q] ? row_rdata : '0;
  assign msum    = {1'b0, acc_q} + {1'b0, div_rsp.rem};

  always_comb begin
    state_d = state_q;
    vld_d   = vld_q;
    func_d  = func_q;
    seg_d   = seg_q;
    idx_d   = idx_q;
    end_d   = end_q;
    last_d  = last_q;
    blk_d   = blk_q;
    rb_d    = rb_q;
    val_d   = val_q;
    mod_d   = mod_q;
    acc_d   = acc_q;
    tot_d   = tot_q;
    pend_d  = pend_q;
    clr_d   = clr_q;
    clr_cnt_d = clr_cnt_q;
    el_we   = 1'b0;
    el_wdata = '0;
    row_we  = 1'b0;
    row_wdata = {tot_q, pend_q};
    div_req.start    = 1'b0;
    div_req.dividend = el_rdata + pend_q;
    div_req.divisor  = mod_q;
    go_seg_end  = 1'b0;
    go_mid_next = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start && !clr_q) begin
          func_d = func_i;
          val_d  = value_i;
          mod_d  = modulus_i;
          last_d = last_index_i;
          idx_d  = first_index_i;
          blk_d  = lb_in;
          rb_d   = rb_in;
          seg_d  = SEG_A;
          acc_d  = '0;
          end_d  = (lb_in == rb_in) ? last_index_i : blk_hi(lb_in);
          if (func_i == FUNC_LOAD) begin
            end_d = first_index_i;
            if ({1'b0, first_index_i} < (IDX_W+1)'(NUM_ELEMENTS)) state_d = S_ROW_RD;
          end else if (func_i == FUNC_ADD) begin
            if (ok) state_d = S_ROW_RD;
          end else if (func_i == FUNC_QUERY) begin
            state_d = (ok && modulus_i != '0) ? S_ROW_RD : S_DONE;
          end
        end
      end
      S_ROW_RD: state_d = S_EL_RD;
      S_EL_RD: begin
        tot_d  = row_in[ROW_W-1:WORD_W];
        pend_d = row_in[WORD_W-1:0];
        if (seg_q == SEG_MID) begin
          if (func_q == FUNC_ADD) begin
            row_we    = 1'b1;
            row_wdata = {row_in[ROW_W-1:WORD_W] + 64'(val_q) * 64'(BLK_LEN),
                         row_in[WORD_W-1:0] + 64'(val_q)};
            vld_d[blk_q] = 1'b1;
            go_mid_next  = 1'b1;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = row_in[ROW_W-1:WORD_W];
            state_d = S_DIV;
          end
        end else begin
          state_d = S_ROW_LD;
        end
      end
      S_ROW_LD: state_d = S_EL_OP;
      S_EL_OP: begin
        if (func_q == FUNC_LOAD) begin
          el_we    = 1'b1;
          el_wdata = 64'(val_q);
          tot_d    = tot_q + 64'(val_q) - el_rdata;
          state_d  = S_ROW_WR;
        end else if (func_q == FUNC_ADD) begin
          el_we    = 1'b1;
          el_wdata = el_rdata + 64'(val_q);
          tot_d    = tot_q + 64'(val_q);
          if (last_el) begin
            state_d = S_ROW_WR;
          end else begin
            idx_d   = IDX_W'(idx_q + 1'b1);
            state_d = S_ROW_LD;
          end
        end else begin
          div_req.start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          acc_d = (msum >= {1'b0, mod_q}) ? 32'(msum - {1'b0, mod_q}) : msum[31:0];
          if (seg_q == SEG_MID) begin
            go_mid_next = 1'b1;
          end else if (last_el) begin
            go_seg_end = 1'b1;
          end else begin
            idx_d   = IDX_W'(idx_q + 1'b1);
            state_d = S_ROW_LD;
          end
        end
      end
      S_ROW_WR: begin
        row_we       = 1'b1;
        vld_d[blk_q] = 1'b1;
        go_seg_end   = 1'b1;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    if (go_mid_next) begin
      state_d = S_ROW_RD;
      if (blk_nx == rb_q) begin
        seg_d = SEG_C;
        idx_d = blk_lo(rb_q);
        end_d = last_q;
        blk_d = rb_q;
      end else begin
        blk_d = blk_nx;
      end
    end

    if (go_seg_end) begin
      if (seg_q == SEG_A && func_q != FUNC_LOAD && blk_q != rb_q) begin
        state_d = S_ROW_RD;
        if (blk_nx == rb_q) begin
          seg_d = SEG_C;
          idx_d = blk_lo(rb_q);
          end_d = last_q;
          blk_d = rb_q;
        end else begin
          seg_d = SEG_MID;
          blk_d = blk_nx;
        end
      end else begin
        state_d = (func_q == FUNC_QUERY) ? S_DONE : S_IDLE;
      end
    end

    if (clr_q) begin
      el_we     = 1'b1;
      el_wdata  = '0;
      clr_cnt_d = EL_AW'(clr_cnt_q + 1'b1);
      if (clr_cnt_q == EL_AW'(NUM_ELEMENTS - 1)) clr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vld_q     <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    seg_q  <= seg_d;
    idx_q  <= idx_d;
    end_q  <= end_d;
    last_q <= last_d;
    blk_q  <= blk_d;
    rb_q   <= rb_d;
    val_q  <= val_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    tot_q  <= tot_d;
    pend_q <= pend_d;
  end

  assign busy            = (state_q != S_IDLE) || clr_q;
  assign sum_mod_valid_o = (state_q == S_DONE);
  assign sum_mod_o       = acc_q;

endmodule

// ----- rtl/rarsm_chk.sv -----
// Port-level checker for the range add / range sum modulo unit, bound to the top level.
// Depends on rarsm_pkg.
module rarsm_chk
  import rarsm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [1:0]       func_i,
  input logic             sum_mod_valid_o,
  input logic [31:0]      sum_mod_o
);

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_mod_valid_o |-> (busy && !$isunknown(sum_mod_o)))
    else $error("result strobe while idle or unknown");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_mod_valid_o |=> !sum_mod_valid_o) else $error("result strobe repeated");

  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_mod_valid_o |=> !busy) else $error("busy after result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_QUERY) |=> busy)
    else $error("query item not taken");

  a_no_strobe_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i != FUNC_QUERY) |=> !sum_mod_valid_o)
    else $error("result without work");

endmodule

bind range_add_range_sum_mod_unit rarsm_chk u_rarsm_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .func_i          (func_i),
  .sum_mod_valid_o (sum_mod_valid_o),
  .sum_mod_o       (sum_mod_o)
);
